FILE: hdl/neighbor_binding_classifier_defines.svh
// Assertion macros for the neighbor binding classifier.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef NEIGHBOR_BINDING_CLASSIFIER_DEFINES_SVH
`define NEIGHBOR_BINDING_CLASSIFIER_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define NBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define NBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/nbc_pkg.sv
// Shared types and constants of the neighbor binding classifier.
// No dependencies; used by the controller, datapath and top level.
package nbc_pkg;

  localparam int unsigned NEIGHBORS_DEF = 32;
  localparam int unsigned ADDRS_DEF     = 4;
  localparam int unsigned OLDMACS_DEF   = 4;

  localparam int unsigned VLAN_W = 12;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned IP_W   = 2 * ADDR_W;
  localparam int unsigned TIME_W = 32;

  // 180 days of seconds
  localparam logic [TIME_W-1:0] INACT_RESET = TIME_W'(6 * 30 * 86400);

  typedef enum logic [2:0] {
    VERD_REFRESH     = 3'd0,
    VERD_NEW_STATION = 3'd1,
    VERD_NEW_LLA     = 3'd2,
    VERD_NEW_IP      = 3'd3,
    VERD_FLIP_FLOP   = 3'd4,
    VERD_REUSED      = 3'd5,
    VERD_CHANGED     = 3'd6
  } verdict_e;

  typedef enum logic [1:0] {
    SEV_QUIET = 2'd0,
    SEV_NEW   = 2'd1,
    SEV_ALARM = 2'd2
  } severity_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the observation
    logic scan_init;  // clear the search trackers for a pass
    logic pass2;      // the pass being started is the link-local rescan
    logic scan_rd;    // read the row named by the scan index
    logic fetch;      // read the target row
    logic update;     // write back the target row and emit the word
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_pass2;
  } stat_t;

endpackage

FILE: hdl/neighbor_binding_classifier.sv
// Each observation takes one scan of the table, and a second scan when a MAC
// change is traced through a global address to its link-local owner.
// Observations are taken only while idle (busy_o low); the table is scanned
// one row per cycle through the single read port of the row memory.
// Reset: asynchronous, clears all entries at once; limit returns to 180 days.
// done_o marks the result word for one cycle; the receiver cannot stall.
`include "neighbor_binding_classifier_defines.svh"
module neighbor_binding_classifier #(
  parameter int unsigned NEIGHBORS = nbc_pkg::NEIGHBORS_DEF,
  parameter int unsigned ADDRS     = nbc_pkg::ADDRS_DEF,
  parameter int unsigned OLDMACS   = nbc_pkg::OLDMACS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [nbc_pkg::TIME_W-1:0] cfg_data_i,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [nbc_pkg::VLAN_W-1:0] vlan_i,
  input  logic [nbc_pkg::MAC_W-1:0]  mac_i,
  input  logic [nbc_pkg::ADDR_W-1:0] addr_high_i,
  input  logic [nbc_pkg::ADDR_W-1:0] addr_low_i,
  input  logic [nbc_pkg::TIME_W-1:0] now_i,
  output logic                       done_o,
  output logic [2:0]                 verdict_o,
  output logic [1:0]                 severity_o,
  output logic                       mac_was_unknown_o,
  output logic                       renewed_activity_o,
  output logic                       store_full_o,
  output logic [nbc_pkg::MAC_W-1:0]  bound_mac_o,
  output logic [nbc_pkg::MAC_W-1:0]  last_mac_o
);
  import nbc_pkg::*;

  cmd_t                         cmd;
  stat_t                        status;
  logic [$clog2(NEIGHBORS)-1:0] scan_idx;
  logic                         sev_ok;

  nbc_ctrl #(
    .NEIGHBORS (NEIGHBORS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .scan_idx_o (scan_idx)
  );

  nbc_datapath #(
    .NEIGHBORS (NEIGHBORS),
    .ADDRS     (ADDRS),
    .OLDMACS   (OLDMACS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .scan_idx_i         (scan_idx),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .vlan_i             (vlan_i),
    .mac_i              (mac_i),
    .addr_high_i        (addr_high_i),
    .addr_low_i         (addr_low_i),
    .now_i              (now_i),
    .done_o             (done_o),
    .verdict_o          (verdict_o),
    .severity_o         (severity_o),
    .mac_was_unknown_o  (mac_was_unknown_o),
    .renewed_activity_o (renewed_activity_o),
    .store_full_o       (store_full_o),
    .bound_mac_o        (bound_mac_o),
    .last_mac_o         (last_mac_o)
  );

  // Pair each verdict class with its severity
  assign sev_ok = (verdict_o == VERD_REFRESH && severity_o == SEV_QUIET) ||
                  ((verdict_o == VERD_NEW_STATION || verdict_o == VERD_NEW_LLA ||
                    verdict_o == VERD_NEW_IP) && severity_o == SEV_NEW) ||
                  ((verdict_o == VERD_FLIP_FLOP || verdict_o == VERD_REUSED ||
                    verdict_o == VERD_CHANGED) && severity_o == SEV_ALARM);

  // A finished word leaves the block idle
  `NBC_ASSERT_NOW(a_done_idle, done_o, !busy_o, "result word while busy")

  // An accepted observation starts work
  `NBC_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "accepted word did not start")

  // Severity follows the verdict class
  `NBC_ASSERT_NOW(a_sev_class, done_o, sev_ok, "severity does not match verdict")

endmodule

FILE: hdl/nbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/nbc_ctrl.sv
// Sequencer of the neighbor binding classifier: scan passes, fetch, update.
// Depends on nbc_pkg for the command and status words.
module nbc_ctrl #(
  parameter int unsigned NEIGHBORS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  nbc_pkg::stat_t               status_i,
  output nbc_pkg::cmd_t                cmd_o,
  output logic [$clog2(NEIGHBORS)-1:0] scan_idx_o
);
  import nbc_pkg::*;

  localparam int unsigned IW = $clog2(NEIGHBORS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DRAIN  = 6'b000100,
    S_DECIDE = 6'b001000,
    S_FETCH  = 6'b010000,
    S_UPDATE = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   cnt_q, cnt_d;
  logic            pass2_q, pass2_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pass2_d = pass2_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load      = 1'b1;
          cmd_o.scan_init = 1'b1;
          cnt_d           = '0;
          pass2_d         = 1'b0;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (cnt_q == IW'(NEIGHBORS - 1)) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (status_i.need_pass2 && !pass2_q) begin
          cmd_o.scan_init = 1'b1;
          cmd_o.pass2     = 1'b1;
          pass2_d         = 1'b1;
          cnt_d           = '0;
          state_d         = S_SCAN;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pass2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass2_q <= pass2_d;
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign scan_idx_o = cnt_q;

endmodule

FILE: hdl/nbc_datapath.sv
// Datapath of the neighbor binding classifier: table row memory, per-entry
// valid bits and counts, search trackers and the row update. Uses nbc_pkg, nbc_ram.
module nbc_datapath #(
  parameter int unsigned NEIGHBORS = 32,
  parameter int unsigned ADDRS     = 4,
  parameter int unsigned OLDMACS   = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nbc_pkg::cmd_t                   cmd_i,
  input  logic [$clog2(NEIGHBORS)-1:0]    scan_idx_i,
  output nbc_pkg::stat_t                  status_o,
  input  logic                            cfg_we_i,
  input  logic [nbc_pkg::TIME_W-1:0]      cfg_data_i,
  input  logic [nbc_pkg::VLAN_W-1:0]      vlan_i,
  input  logic [nbc_pkg::MAC_W-1:0]       mac_i,
  input  logic [nbc_pkg::ADDR_W-1:0]      addr_high_i,
  input  logic [nbc_pkg::ADDR_W-1:0]      addr_low_i,
  input  logic [nbc_pkg::TIME_W-1:0]      now_i,
  output logic                            done_o,
  output logic [2:0]                      verdict_o,
  output logic [1:0]                      severity_o,
  output logic                            mac_was_unknown_o,
  output logic                            renewed_activity_o,
  output logic                            store_full_o,
  output logic [nbc_pkg::MAC_W-1:0]       bound_mac_o,
  output logic [nbc_pkg::MAC_W-1:0]       last_mac_o
);
  import nbc_pkg::*;

  localparam int unsigned IW       = $clog2(NEIGHBORS);
  localparam int unsigned CW       = $clog2(OLDMACS + 1);
  localparam int unsigned OFF_MAC  = VLAN_W;
  localparam int unsigned OFF_LLA  = OFF_MAC + MAC_W;
  localparam int unsigned OFF_PREV = OFF_LLA + IP_W;
  localparam int unsigned OFF_SEEN = OFF_PREV + MAC_W;
  localparam int unsigned OFF_GA   = OFF_SEEN + TIME_W;
  localparam int unsigned OFF_FM   = OFF_GA + ADDRS * IP_W;
  localparam int unsigned ROW_W    = OFF_FM + OLDMACS * MAC_W;

  typedef enum logic [2:0] {
    BR_NEW    = 3'd0,
    BR_LLA    = 3'd1,
    BR_IP     = 3'd2,
    BR_KNOWN  = 3'd3,
    BR_REBIND = 3'd4
  } branch_e;

  // Observation and configuration
  logic [VLAN_W-1:0] vlan_q;
  logic [MAC_W-1:0]  mac_q;
  logic [IP_W-1:0]   addr_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] limit_q;
  logic              ll, mc;

  // Per-entry flip-flop state
  logic              entry_valid_q [NEIGHBORS];
  logic [ADDRS-1:0]  gvalid_q      [NEIGHBORS];
  logic [CW-1:0]     fcount_q      [NEIGHBORS];

  // Search trackers
  logic              cmp_en_q;
  logic [IW-1:0]     cmp_idx_q;
  logic              pass2_q;
  logic              m_found_q, lla1_found_q, ip_found_q, free_found_q, e_found_q;
  logic [IW-1:0]     m_idx_q, free_idx_q, e_idx_q;
  logic [IP_W-1:0]   ip_lla_q;

  // Row memory
  logic [ROW_W-1:0]  rd_row, wr_row;
  logic              row_we;
  logic [IW-1:0]     tgt, vidx, rd_addr;

  // Row fields
  logic [VLAN_W-1:0] r_vlan;
  logic [MAC_W-1:0]  r_mac, r_prev;
  logic [IP_W-1:0]   r_lla;
  logic [TIME_W-1:0] r_seen;
  logic [IP_W-1:0]   r_ga [ADDRS];
  logic [MAC_W-1:0]  r_fm [OLDMACS];

  // Scan compare
  logic              v_t;
  logic [ADDRS-1:0]  gv_t;
  logic [CW-1:0]     fc_t;
  logic              in_vlan, mac_hit, lla_hit, ip_hit, has_ip_t;
  logic [IP_W-1:0]   lla_key;
  branch_e           br;

  // Update
  logic [ADDRS-1:0]  ins_oh, gv_new;
  logic              renewed, has_former;
  logic [CW-1:0]     n1, n2, n3, fc_new;
  logic [MAC_W-1:0]  list1 [OLDMACS];
  logic [MAC_W-1:0]  list2 [OLDMACS];
  logic [OLDMACS-1:0] hit, pre;
  logic [VLAN_W-1:0] n_vlan;
  logic [MAC_W-1:0]  n_mac, n_prev;
  logic [IP_W-1:0]   n_lla;
  logic [TIME_W-1:0] n_seen;
  logic [IP_W-1:0]   n_ga [ADDRS];
  logic [MAC_W-1:0]  n_fm [OLDMACS];
  logic              upd_we;
  logic              u_full, u_renewed;
  verdict_e          u_verdict;
  severity_e         u_sev;
  logic [MAC_W-1:0]  u_bound, u_last;

  assign ll = (addr_q[IP_W-1 -: 10] == 10'h3FA);
  assign mc = (addr_q[IP_W-1 -: 8] == 8'hFF);

  // Capture the observation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vlan_q <= vlan_i;
      mac_q  <= mac_i;
      addr_q <= {addr_high_i, addr_low_i};
      now_q  <= now_i;
    end
  end

  // Inactivity limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= INACT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Row memory, one row per entry
  assign rd_addr = cmd_i.fetch ? tgt : scan_idx_i;

  nbc_ram #(
    .Width (ROW_W),
    .Depth (NEIGHBORS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (tgt),
    .wdata_i (wr_row),
    .re_i    (cmd_i.scan_rd | cmd_i.fetch),
    .raddr_i (rd_addr),
    .rdata_o (rd_row)
  );

  // Unpack the row read back
  always_comb begin
    r_vlan = rd_row[0 +: VLAN_W];
    r_mac  = rd_row[OFF_MAC +: MAC_W];
    r_lla  = rd_row[OFF_LLA +: IP_W];
    r_prev = rd_row[OFF_PREV +: MAC_W];
    r_seen = rd_row[OFF_SEEN +: TIME_W];
    for (int k = 0; k < ADDRS; k++) begin
      r_ga[k] = rd_row[OFF_GA + k * IP_W +: IP_W];
    end
    for (int k = 0; k < OLDMACS; k++) begin
      r_fm[k] = rd_row[OFF_FM + k * MAC_W +: MAC_W];
    end
  end

  // Per-entry state of the row being compared or updated
  assign vidx = cmp_en_q ? cmp_idx_q : tgt;
  assign v_t  = entry_valid_q[vidx];
  assign gv_t = gvalid_q[vidx];
  assign fc_t = fcount_q[vidx];

  // Compare the row against the observation
  assign lla_key = pass2_q ? ip_lla_q : addr_q;
  assign in_vlan = v_t && ((vlan_q == '0) || (r_vlan == vlan_q));
  assign mac_hit = in_vlan && (r_mac == mac_q);
  assign lla_hit = in_vlan && (r_lla == lla_key);
  always_comb begin
    has_ip_t = 1'b0;
    for (int k = 0; k < ADDRS; k++) begin
      has_ip_t = has_ip_t | (gv_t[k] && (r_ga[k] == addr_q));
    end
  end
  assign ip_hit = in_vlan && has_ip_t;

  // Track the lowest hit of each search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_en_q     <= 1'b0;
      cmp_idx_q    <= '0;
      pass2_q      <= 1'b0;
      m_found_q    <= 1'b0;
      lla1_found_q <= 1'b0;
      ip_found_q   <= 1'b0;
      free_found_q <= 1'b0;
      e_found_q    <= 1'b0;
      m_idx_q      <= '0;
      free_idx_q   <= '0;
      e_idx_q      <= '0;
      ip_lla_q     <= '0;
    end else begin
      cmp_en_q  <= cmd_i.scan_rd;
      cmp_idx_q <= scan_idx_i;
      if (cmd_i.scan_init) begin
        pass2_q   <= cmd_i.pass2;
        e_found_q <= 1'b0;
        if (!cmd_i.pass2) begin
          m_found_q    <= 1'b0;
          lla1_found_q <= 1'b0;
          ip_found_q   <= 1'b0;
          free_found_q <= 1'b0;
        end
      end else if (cmp_en_q) begin
        if (!pass2_q) begin
          if (mac_hit && !m_found_q) begin
            m_found_q <= 1'b1;
            m_idx_q   <= cmp_idx_q;
          end
          if (lla_hit) begin
            lla1_found_q <= 1'b1;
          end
          if (ip_hit && !ip_found_q) begin
            ip_found_q <= 1'b1;
            ip_lla_q   <= r_lla;
          end
          if (!v_t && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= cmp_idx_q;
          end
        end
        if (lla_hit && !e_found_q) begin
          e_found_q <= 1'b1;
          e_idx_q   <= cmp_idx_q;
        end
      end
    end
  end

  // Classify from the first pass
  always_comb begin
    priority if (!m_found_q) begin
      br = (lla1_found_q || ip_found_q) ? BR_REBIND : BR_NEW;
    end else if (!lla1_found_q && ll) begin
      br = BR_LLA;
    end else if (!ip_found_q && !ll) begin
      br = BR_IP;
    end else begin
      br = BR_KNOWN;
    end
  end

  assign status_o.need_pass2 = (br == BR_REBIND) && !ll && ip_found_q;

  always_comb begin
    unique case (br)
      BR_NEW:    tgt = free_idx_q;
      BR_REBIND: tgt = e_idx_q;
      default:   tgt = m_idx_q;
    endcase
  end

  // First free global address slot
  always_comb begin
    logic below_full;
    below_full = 1'b1;
    for (int k = 0; k < ADDRS; k++) begin
      ins_oh[k]  = below_full && !gv_t[k];
      below_full = below_full && gv_t[k];
    end
  end

  assign renewed = (now_q > r_seen) && ((now_q - r_seen) > limit_q);

  // Former MAC list: evict oldest if full, append, drop first copy of new MAC
  always_comb begin
    has_former = 1'b0;
    for (int k = 0; k < OLDMACS; k++) begin
      has_former = has_former | ((CW'(k) < fc_t) && (r_fm[k] == mac_q));
    end
    n1 = (fc_t == CW'(OLDMACS)) ? CW'(OLDMACS - 1) : fc_t;
    n2 = n1 + 1'b1;
    for (int k = 0; k < OLDMACS; k++) begin
      if (CW'(k) < n1) begin
        if (fc_t == CW'(OLDMACS)) begin
          list1[k] = (k + 1 < OLDMACS) ? r_fm[(k + 1) % OLDMACS] : '0;
        end else begin
          list1[k] = r_fm[k];
        end
      end else if (CW'(k) == n1) begin
        list1[k] = r_mac;
      end else begin
        list1[k] = '0;
      end
      hit[k] = (CW'(k) < n2) && (list1[k] == mac_q);
    end
    for (int k = 0; k < OLDMACS; k++) begin
      pre[k] = (k == 0) ? hit[0] : (pre[(k + OLDMACS - 1) % OLDMACS] | hit[k]);
    end
    for (int k = 0; k < OLDMACS; k++) begin
      if (pre[k]) begin
        list2[k] = (k + 1 < OLDMACS) ? list1[(k + 1) % OLDMACS] : '0;
      end else begin
        list2[k] = list1[k];
      end
    end
    n3 = n2 - CW'(pre[OLDMACS-1]);
  end

  // Row update for the chosen case
  always_comb begin
    n_vlan    = r_vlan;
    n_mac     = r_mac;
    n_lla     = r_lla;
    n_prev    = r_prev;
    n_seen    = r_seen;
    n_ga      = r_ga;
    n_fm      = r_fm;
    gv_new    = gv_t;
    fc_new    = fc_t;
    upd_we    = 1'b0;
    u_full    = 1'b0;
    u_renewed = 1'b0;
    u_verdict = VERD_REFRESH;
    u_sev     = SEV_QUIET;
    u_bound   = '0;
    u_last    = '0;
    unique case (br)
      BR_NEW: begin
        u_verdict = VERD_NEW_STATION;
        u_sev     = SEV_NEW;
        if (free_found_q) begin
          upd_we    = 1'b1;
          n_vlan    = vlan_q;
          n_mac     = mac_q;
          n_lla     = ll ? addr_q : '0;
          n_prev    = '0;
          n_seen    = now_q;
          n_ga[0]   = addr_q;
          gv_new    = (!ll && !mc) ? ADDRS'(1) : '0;
          fc_new    = '0;
        end else begin
          u_full = 1'b1;
        end
      end
      BR_LLA: begin
        u_verdict = VERD_NEW_LLA;
        u_sev     = SEV_NEW;
        upd_we    = 1'b1;
        n_lla     = addr_q;
        n_seen    = now_q;
        u_renewed = renewed;
      end
      BR_IP, BR_KNOWN: begin
        if (br == BR_IP) begin
          u_verdict = VERD_NEW_IP;
          u_sev     = SEV_NEW;
        end
        upd_we    = 1'b1;
        n_seen    = now_q;
        u_renewed = renewed;
        if (!mc && !(br == BR_KNOWN && (ll || has_ip_t))) begin
          if (|ins_oh) begin
            for (int k = 0; k < ADDRS; k++) begin
              if (ins_oh[k]) begin
                n_ga[k] = addr_q;
              end
            end
            gv_new = gv_t | ins_oh;
          end else begin
            u_full = 1'b1;
          end
        end
      end
      BR_REBIND: begin
        if (e_found_q) begin
          upd_we  = 1'b1;
          u_sev   = SEV_ALARM;
          u_bound = r_mac;
          if (has_former) begin
            u_last    = r_prev;
            u_verdict = (r_prev == mac_q) ? VERD_FLIP_FLOP : VERD_REUSED;
          end else begin
            u_verdict = VERD_CHANGED;
          end
          n_fm   = list2;
          fc_new = n3;
          n_prev = r_mac;
          n_mac  = mac_q;
        end
      end
      default: begin
        upd_we = 1'b0;
      end
    endcase
  end

  // Pack the row to write back
  always_comb begin
    wr_row                      = '0;
    wr_row[0 +: VLAN_W]         = n_vlan;
    wr_row[OFF_MAC +: MAC_W]    = n_mac;
    wr_row[OFF_LLA +: IP_W]     = n_lla;
    wr_row[OFF_PREV +: MAC_W]   = n_prev;
    wr_row[OFF_SEEN +: TIME_W]  = n_seen;
    for (int k = 0; k < ADDRS; k++) begin
      wr_row[OFF_GA + k * IP_W +: IP_W] = n_ga[k];
    end
    for (int k = 0; k < OLDMACS; k++) begin
      wr_row[OFF_FM + k * MAC_W +: MAC_W] = n_fm[k];
    end
  end

  // Write the row only in the update cycle
  assign row_we = upd_we & cmd_i.update;

  // Per-entry flags and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NEIGHBORS; i++) begin
        entry_valid_q[i] <= 1'b0;
        gvalid_q[i]      <= '0;
        fcount_q[i]      <= '0;
      end
    end else if (row_we) begin
      entry_valid_q[tgt] <= 1'b1;
      gvalid_q[tgt]      <= gv_new;
      fcount_q[tgt]      <= fc_new;
    end
  end

  // Result word, shown for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.update;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      verdict_o          <= u_verdict;
      severity_o         <= u_sev;
      mac_was_unknown_o  <= !m_found_q;
      renewed_activity_o <= u_renewed;
      store_full_o       <= u_full;
      bound_mac_o        <= u_bound;
      last_mac_o         <= u_last;
    end
  end

endmodule
